// ----- src/qcdc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcdc_pkg
// Shared widths, types and datapath step functions for the corner drift check.
// ----------------------------------------------------------------------------
package qcdc_pkg;

	localparam int COORD_W         = 16;
	localparam int COORD_FRAC_BITS = 4;
	localparam int RATIO_FRAC_BITS = 12;
	localparam int SQRT_FRAC_BITS  = 12;
	localparam int RATIO_W         = 16;
	localparam int THR_W           = 13;
	localparam int NUM_CORNERS     = 4;
	localparam int NUM_REGS        = 2 * NUM_CORNERS;
	localparam int REG_SEL_W       = $clog2(NUM_REGS);
	localparam int CFG_IDX_W       = REG_SEL_W + 1;

	localparam int DIFF_W  = COORD_W + 1;
	localparam int EXT_W   = COORD_W + 2;
	localparam int SQ_W    = 2 * COORD_W;
	localparam int M_W     = SQ_W + 1;
	localparam int SCALE_W = COORD_W + 1;

	// square root
	localparam int SQ_IN_W   = M_W + 2 * SQRT_FRAC_BITS;
	localparam int ROOT_W    = (SQ_IN_W + 1) / 2;
	localparam int SQ_PAD_W  = 2 * ROOT_W;
	localparam int SQ_REM_W  = ROOT_W + 2;
	localparam int SQ_STEPS  = 2;
	localparam int SQ_STAGES = (ROOT_W + SQ_STEPS - 1) / SQ_STEPS;

	// divide
	localparam int NUM_W      = ROOT_W + RATIO_FRAC_BITS + 1;
	localparam int DEN_W      = SCALE_W + SQRT_FRAC_BITS;
	localparam int DIV_REM_W  = DEN_W + 1;
	localparam int HI_W       = NUM_W - RATIO_W;
	localparam int CMP_W      = (HI_W > DEN_W) ? HI_W : DEN_W;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = (RATIO_W + DIV_STEPS - 1) / DIV_STEPS;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic               degen;
		logic [SCALE_W-1:0] scale;
		logic [THR_W-1:0]   thr;
	} side_t;

	typedef struct packed {
		logic [SQ_REM_W-1:0] rem;
		logic [ROOT_W-1:0]   root;
		logic [SQ_PAD_W-1:0] x;
	} sq_state_t;

	typedef struct packed {
		logic [DIV_REM_W-1:0] r;
		logic [RATIO_W-1:0]   q;
		logic [RATIO_W-1:0]   n;
	} div_state_t;

	// one result bit of the digit-by-digit square root
	function automatic sq_state_t sqrt_step(input sq_state_t s);
		logic [SQ_REM_W-1:0] r;
		logic [SQ_REM_W-1:0] t;
		sq_state_t o;
		r = {s.rem[SQ_REM_W-3:0], s.x[SQ_PAD_W-1 -: 2]};
		t = {s.root, 2'b01};
		o.x = {s.x[SQ_PAD_W-3:0], 2'b00};
		if (r >= t) begin
			o.rem  = r - t;
			o.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			o.rem  = r;
			o.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return o;
	endfunction

	// one quotient bit of restoring division
	function automatic div_state_t div_step(input div_state_t s, input logic [DEN_W-1:0] den);
		logic [DIV_REM_W-1:0] r;
		div_state_t o;
		r = {s.r[DEN_W-1:0], s.n[RATIO_W-1]};
		o.n = {s.n[RATIO_W-2:0], 1'b0};
		if (r >= {1'b0, den}) begin
			o.r = r - {1'b0, den};
			o.q = {s.q[RATIO_W-2:0], 1'b1};
		end else begin
			o.r = r;
			o.q = {s.q[RATIO_W-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage

// ----- src/qcdc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcdc_front
// Corner deltas, squared distances, extents and the largest distance.
// ----------------------------------------------------------------------------
module qcdc_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  qcdc_pkg::coord_t             nx [qcdc_pkg::NUM_CORNERS],
	input  qcdc_pkg::coord_t             ny [qcdc_pkg::NUM_CORNERS],
	input  qcdc_pkg::coord_t             rx [qcdc_pkg::NUM_CORNERS],
	input  qcdc_pkg::coord_t             ry [qcdc_pkg::NUM_CORNERS],
	input  logic [qcdc_pkg::THR_W-1:0]   thr,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [qcdc_pkg::M_W-1:0]     m,
	output qcdc_pkg::side_t              side_out
);
	import qcdc_pkg::*;

	localparam logic signed [EXT_W-1:0] ONE2 = EXT_W'(2 ** (COORD_FRAC_BITS + 1));

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	logic signed [DIFF_W-1:0] dx_s1 [NUM_CORNERS];
	logic signed [DIFF_W-1:0] dy_s1 [NUM_CORNERS];
	logic signed [EXT_W-1:0]  v2_s1, h2_s1;
	logic [THR_W-1:0]         thr_s1;

	logic [SQ_W-1:0] sqx_s2 [NUM_CORNERS];
	logic [SQ_W-1:0] sqy_s2 [NUM_CORNERS];
	side_t           side_s2;

	logic [M_W-1:0] d_s3 [NUM_CORNERS];
	side_t          side_s3;

	logic [M_W-1:0] m_s4;
	side_t          side_s4;

	logic signed [DIFF_W-1:0]   dx_c [NUM_CORNERS];
	logic signed [DIFF_W-1:0]   dy_c [NUM_CORNERS];
	logic signed [2*DIFF_W-1:0] px [NUM_CORNERS];
	logic signed [2*DIFF_W-1:0] py [NUM_CORNERS];
	logic signed [EXT_W-1:0]    v2_c, h2_c;
	side_t                      side_c;
	logic [M_W-1:0]             m01, m23;

	assign adv4     = !v_s4 || out_ready;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_comb begin
		for (int i = 0; i < NUM_CORNERS; i++) begin
			dx_c[i] = DIFF_W'(rx[i]) - DIFF_W'(nx[i]);
			dy_c[i] = DIFF_W'(ry[i]) - DIFF_W'(ny[i]);
			px[i]   = dx_s1[i] * dx_s1[i];
			py[i]   = dy_s1[i] * dy_s1[i];
		end
		v2_c = (EXT_W'(ny[2]) + EXT_W'(ny[3])) - (EXT_W'(ny[0]) + EXT_W'(ny[1]));
		h2_c = (EXT_W'(nx[1]) + EXT_W'(nx[2])) - (EXT_W'(nx[0]) + EXT_W'(nx[3]));
		side_c.degen = (v2_s1 < ONE2) || (h2_s1 < ONE2);
		side_c.scale = (h2_s1 > v2_s1) ? h2_s1[SCALE_W-1:0] : v2_s1[SCALE_W-1:0];
		side_c.thr   = thr_s1;
		m01 = (d_s3[1] > d_s3[0]) ? d_s3[1] : d_s3[0];
		m23 = (d_s3[3] > d_s3[2]) ? d_s3[3] : d_s3[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1   <= in_valid;
				dx_s1  <= dx_c;
				dy_s1  <= dy_c;
				v2_s1  <= v2_c;
				h2_s1  <= h2_c;
				thr_s1 <= thr;
			end
			if (adv2) begin
				v_s2 <= v_s1;
				for (int i = 0; i < NUM_CORNERS; i++) begin
					// deltas fit 17 bits, so squares are below 2^32
					sqx_s2[i] <= px[i][SQ_W-1:0];
					sqy_s2[i] <= py[i][SQ_W-1:0];
				end
				side_s2 <= side_c;
			end
			if (adv3) begin
				v_s3 <= v_s2;
				for (int i = 0; i < NUM_CORNERS; i++)
					d_s3[i] <= M_W'(sqx_s2[i]) + M_W'(sqy_s2[i]);
				side_s3 <= side_s2;
			end
			if (adv4) begin
				v_s4    <= v_s3;
				m_s4    <= (m23 > m01) ? m23 : m01;
				side_s4 <= side_s3;
			end
		end
	end

	assign out_valid = v_s4;
	assign m         = m_s4;
	assign side_out  = side_s4;

endmodule

// ----- src/qcdc_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcdc_sqrt
// Pipelined integer square root of the scaled largest squared distance.
// ----------------------------------------------------------------------------
module qcdc_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [qcdc_pkg::M_W-1:0]      m,
	input  qcdc_pkg::side_t               side_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [qcdc_pkg::ROOT_W-1:0]   root,
	output qcdc_pkg::side_t               side_out
);
	import qcdc_pkg::*;

	localparam int NS = SQ_STAGES;

	logic [NS-1:0] v_s;
	logic [NS-1:0] adv;
	sq_state_t     st_s   [NS];
	side_t         side_s [NS];
	sq_state_t     nxt    [NS];
	sq_state_t     cur;

	always_comb begin
		adv[NS-1] = !v_s[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--)
			adv[k] = !v_s[k] || adv[k+1];
	end
	assign in_ready = adv[0];

	always_comb begin
		cur.rem  = '0;
		cur.root = '0;
		cur.x    = SQ_PAD_W'(m) << (2 * SQRT_FRAC_BITS);
		for (int j = 0; j < SQ_STEPS; j++)
			if (j < ROOT_W)
				cur = sqrt_step(cur);
		nxt[0] = cur;
		for (int k = 1; k < NS; k++) begin
			cur = st_s[k-1];
			for (int j = 0; j < SQ_STEPS; j++)
				if (k * SQ_STEPS + j < ROOT_W)
					cur = sqrt_step(cur);
			nxt[k] = cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (adv[0]) begin
				v_s[0]    <= in_valid;
				st_s[0]   <= nxt[0];
				side_s[0] <= side_in;
			end
			for (int k = 1; k < NS; k++) begin
				if (adv[k]) begin
					v_s[k]    <= v_s[k-1];
					st_s[k]   <= nxt[k];
					side_s[k] <= side_s[k-1];
				end
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign root      = st_s[NS-1].root;
	assign side_out  = side_s[NS-1];

endmodule

// ----- src/qcdc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcdc_div
// Pipelined restoring divide of the root by the scale, with saturation.
// ----------------------------------------------------------------------------
module qcdc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [qcdc_pkg::ROOT_W-1:0]   root,
	input  qcdc_pkg::side_t               side_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [qcdc_pkg::RATIO_W-1:0]  quot,
	output logic                          sat,
	output qcdc_pkg::side_t               side_out
);
	import qcdc_pkg::*;

	localparam int NS = DIV_STAGES + 1;

	logic [NS-1:0]    v_s;
	logic [NS-1:0]    adv;
	div_state_t       st_s   [NS];
	side_t            side_s [NS];
	logic [DEN_W-1:0] den_s  [NS];
	logic             sat_s  [NS];
	div_state_t       nxt    [NS];
	div_state_t       cur;

	logic [NUM_W-1:0] num;
	logic [HI_W-1:0]  hi;
	logic [DEN_W-1:0] den_c;
	logic             sat_c;

	always_comb begin
		adv[NS-1] = !v_s[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--)
			adv[k] = !v_s[k] || adv[k+1];
	end
	assign in_ready = adv[0];

	// first stage only lines up the operands and checks for overflow
	always_comb begin
		num   = NUM_W'(root) << (RATIO_FRAC_BITS + 1);
		hi    = num[NUM_W-1:RATIO_W];
		den_c = DEN_W'(side_in.scale) << SQRT_FRAC_BITS;
		sat_c = CMP_W'(hi) >= CMP_W'(den_c);
		nxt[0].r = DIV_REM_W'(hi);
		nxt[0].q = '0;
		nxt[0].n = num[RATIO_W-1:0];
		for (int k = 1; k < NS; k++) begin
			cur = st_s[k-1];
			for (int j = 0; j < DIV_STEPS; j++)
				if ((k - 1) * DIV_STEPS + j < RATIO_W)
					cur = div_step(cur, den_s[k-1]);
			nxt[k] = cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (adv[0]) begin
				v_s[0]    <= in_valid;
				st_s[0]   <= nxt[0];
				side_s[0] <= side_in;
				den_s[0]  <= den_c;
				sat_s[0]  <= sat_c;
			end
			for (int k = 1; k < NS; k++) begin
				if (adv[k]) begin
					v_s[k]    <= v_s[k-1];
					st_s[k]   <= nxt[k];
					side_s[k] <= side_s[k-1];
					den_s[k]  <= den_s[k-1];
					sat_s[k]  <= sat_s[k-1];
				end
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign quot      = st_s[NS-1].q;
	assign sat       = sat_s[NS-1];
	assign side_out  = side_s[NS-1];

endmodule

// ----- src/quad_corner_drift_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_corner_drift_check
// Stages from input accept to result: 4 front, 15 root, 9 divide, 1 output.
// Throughput: one item per cycle while out_stall is low; stalls squeeze out
// bubbles. Root and divide stages resolve up to two result bits per stage.
// Reset clears all valid bits and the reference corners to zero.
// ----------------------------------------------------------------------------
module quad_corner_drift_check (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  qcdc_pkg::coord_t                    corner0_x,
	input  qcdc_pkg::coord_t                    corner0_y,
	input  qcdc_pkg::coord_t                    corner1_x,
	input  qcdc_pkg::coord_t                    corner1_y,
	input  qcdc_pkg::coord_t                    corner2_x,
	input  qcdc_pkg::coord_t                    corner2_y,
	input  qcdc_pkg::coord_t                    corner3_x,
	input  qcdc_pkg::coord_t                    corner3_y,
	input  logic [qcdc_pkg::THR_W-1:0]          threshold,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                is_close,
	output logic                                degenerate,
	output logic [qcdc_pkg::RATIO_W-1:0]        max_ratio,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [qcdc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [qcdc_pkg::COORD_W-1:0]        cfg_data
);
	import qcdc_pkg::*;

	logic [COORD_W-1:0] ref_q [NUM_REGS];

	coord_t nx [NUM_CORNERS];
	coord_t ny [NUM_CORNERS];
	coord_t rx [NUM_CORNERS];
	coord_t ry [NUM_CORNERS];

	logic              fr_ready, fr_valid, sq_ready, sq_valid, dv_ready, dv_valid, out_ready;
	logic [M_W-1:0]    fr_m;
	side_t             fr_side, sq_side, dv_side;
	logic [ROOT_W-1:0] sq_root;
	logic [RATIO_W-1:0] dv_quot, ratio_c;
	logic              dv_sat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				ref_q[i] <= '0;
		end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
			ref_q[cfg_index[REG_SEL_W-1:0]] <= cfg_data;
		end
	end

	assign nx[0] = corner0_x;
	assign ny[0] = corner0_y;
	assign nx[1] = corner1_x;
	assign ny[1] = corner1_y;
	assign nx[2] = corner2_x;
	assign ny[2] = corner2_y;
	assign nx[3] = corner3_x;
	assign ny[3] = corner3_y;

	always_comb begin
		for (int i = 0; i < NUM_CORNERS; i++) begin
			rx[i] = coord_t'(ref_q[2*i]);
			ry[i] = coord_t'(ref_q[2*i+1]);
		end
	end

	qcdc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (fr_ready),
		.nx        (nx),
		.ny        (ny),
		.rx        (rx),
		.ry        (ry),
		.thr       (threshold),
		.out_valid (fr_valid),
		.out_ready (sq_ready),
		.m         (fr_m),
		.side_out  (fr_side)
	);

	qcdc_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (sq_ready),
		.m         (fr_m),
		.side_in   (fr_side),
		.out_valid (sq_valid),
		.out_ready (dv_ready),
		.root      (sq_root),
		.side_out  (sq_side)
	);

	qcdc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.in_ready  (dv_ready),
		.root      (sq_root),
		.side_in   (sq_side),
		.out_valid (dv_valid),
		.out_ready (out_ready),
		.quot      (dv_quot),
		.sat       (dv_sat),
		.side_out  (dv_side)
	);

	assign in_stall  = !fr_ready;
	assign out_ready = !out_valid || !out_stall;

	always_comb begin
		if (dv_side.degen)
			ratio_c = '0;
		else if (dv_sat)
			ratio_c = '1;
		else
			ratio_c = dv_quot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_ready) begin
			out_valid  <= dv_valid;
			degenerate <= dv_side.degen;
			max_ratio  <= ratio_c;
			is_close   <= !dv_side.degen && (ratio_c < RATIO_W'(dv_side.thr));
		end
	end

endmodule

// ----- src/qcdc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcdc_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module qcdc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          is_close,
	input logic                          degenerate,
	input logic [qcdc_pkg::RATIO_W-1:0]  max_ratio
);
	import qcdc_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	a_hold_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(max_ratio))
		else $error("stalled ratio changed");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> !is_close && (max_ratio == '0))
		else $error("degenerate item with ratio or close flag");

	// threshold is 13 bits, so a close item has a small ratio
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_close |-> (max_ratio[RATIO_W-1:THR_W] == '0) && !degenerate)
		else $error("close item with out-of-range ratio");

endmodule

bind quad_corner_drift_check qcdc_checker u_qcdc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.is_close   (is_close),
	.degenerate (degenerate),
	.max_ratio  (max_ratio)
);
